// ===== rtl/sfc_pkg.sv =====
`default_nettype none
package sfc_pkg;

  localparam int PlanesFinite   = 6;
  localparam int PlanesInfinite = 5;
  localparam int FracAlign      = 14;  // Q16.16 -> Q.30
  localparam int DistW          = 50;  // three 48-bit products plus a 46-bit offset

  typedef logic signed [15:0] normal_comp_t;
  typedef logic signed [31:0] coord_t;
  typedef logic [30:0]        radius_t;
  typedef logic [44:0]        rad_q30_t;
  typedef logic [2:0]         plane_idx_t;
  typedef logic [1:0]         aspect_t;
  typedef logic               action_t;

  localparam action_t ACTION_LOAD = 1'b0;
  localparam action_t ACTION_TEST = 1'b1;

  localparam aspect_t ASPECT_INSIDE    = 2'd0;
  localparam aspect_t ASPECT_OUTSIDE   = 2'd1;
  localparam aspect_t ASPECT_INTERSECT = 2'd2;

  typedef struct packed {
    normal_comp_t normal_x;
    normal_comp_t normal_y;
    normal_comp_t normal_z;
    coord_t       offset;
  } plane_t;

  typedef struct packed {
    logic below;  // distance < -radius
    logic touch;  // distance <= radius
  } lane_flags_t;

endpackage
`default_nettype wire

// ===== rtl/sfc_ifs.sv =====
`default_nettype none
interface sfc_in_if;
  logic                  valid;
  logic                  ready;
  sfc_pkg::action_t      action;
  sfc_pkg::plane_idx_t   plane_index;
  sfc_pkg::normal_comp_t normal_x;
  sfc_pkg::normal_comp_t normal_y;
  sfc_pkg::normal_comp_t normal_z;
  sfc_pkg::coord_t       plane_offset;
  sfc_pkg::coord_t       center_x;
  sfc_pkg::coord_t       center_y;
  sfc_pkg::coord_t       center_z;
  sfc_pkg::radius_t      sphere_radius;

  modport source (
    output valid, action, plane_index, normal_x, normal_y, normal_z, plane_offset,
           center_x, center_y, center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, action, plane_index, normal_x, normal_y, normal_z, plane_offset,
           center_x, center_y, center_z, sphere_radius,
    output ready
  );
endinterface

interface sfc_out_if;
  logic              valid;
  logic              ready;
  sfc_pkg::aspect_t  aspect;

  modport source (output valid, aspect, input ready);
  modport sink (input valid, aspect, output ready);
endinterface

interface sfc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfc_plane_store.sv =====
`default_nettype none
module sfc_plane_store #(
  parameter int MAX_PLANES = 6
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire sfc_pkg::plane_idx_t wr_idx,
  input  wire sfc_pkg::plane_t     wr_plane,
  output sfc_pkg::plane_t          planes[MAX_PLANES]
);

  sfc_pkg::plane_t planes_r[MAX_PLANES];

  // index beyond the store matches no entry, so such loads are dropped
  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (wr_en && (32'(wr_idx) == i)) begin
        planes_r[i] <= wr_plane;
      end
    end
    assign planes[i] = planes_r[i];
  end

endmodule
`default_nettype wire

// ===== rtl/sfc_lane.sv =====
`default_nettype none
module sfc_lane (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire sfc_pkg::plane_t     plane,
  input  wire sfc_pkg::coord_t     cx,
  input  wire sfc_pkg::coord_t     cy,
  input  wire sfc_pkg::coord_t     cz,
  input  wire sfc_pkg::rad_q30_t   rad,    // aligned with the sum stage
  output sfc_pkg::lane_flags_t     flags
);

  logic signed [47:0]                 px_r, py_r, pz_r;
  logic signed [45:0]                 off_r;
  logic signed [sfc_pkg::DistW-1:0]   dist_r;
  logic signed [sfc_pkg::DistW:0]     dist_ext;
  logic signed [sfc_pkg::DistW:0]     rad_ext;
  logic signed [sfc_pkg::DistW:0]     margin;
  sfc_pkg::lane_flags_t               flags_r;

  assign dist_ext = (sfc_pkg::DistW+1)'(dist_r);
  assign rad_ext  = $signed((sfc_pkg::DistW+1)'(rad));
  assign margin   = dist_ext + rad_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      // Q2.14 x Q16.16 -> Q.30
      px_r    <= plane.normal_x * cx;
      py_r    <= plane.normal_y * cy;
      pz_r    <= plane.normal_z * cz;
      off_r   <= $signed({plane.offset, {sfc_pkg::FracAlign{1'b0}}});
      dist_r  <= sfc_pkg::DistW'(px_r) + sfc_pkg::DistW'(py_r)
               + sfc_pkg::DistW'(pz_r) + sfc_pkg::DistW'(off_r);
      flags_r.below <= margin[sfc_pkg::DistW];
      flags_r.touch <= (dist_ext <= rad_ext);
    end
  end

  assign flags = flags_r;

endmodule
`default_nettype wire

// ===== rtl/sphere_frustum_classifier_top.sv =====
// Path: a test request passes the centre registers, lane products, sum, flags and output register.
// Throughput: one request per cycle while the output is not stalled; loads take a slot and give no result.
// The whole pipeline holds while a result waits at the output, so a request
// is taken whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) clears valid bits and far_off_r; planes
// hold garbage until loaded.
`default_nettype none
module sphere_frustum_classifier_top #(
  parameter int MAX_PLANES = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sfc_in_if.sink     in_ch,
  sfc_out_if.source  out_ch,
  sfc_cfg_if.sink    cfg_ch
);

  localparam int NumFin   = (MAX_PLANES < sfc_pkg::PlanesFinite) ?
                            MAX_PLANES : sfc_pkg::PlanesFinite;
  localparam int NumInf   = (MAX_PLANES < sfc_pkg::PlanesInfinite) ?
                            MAX_PLANES : sfc_pkg::PlanesInfinite;
  localparam int NumLanes = NumFin;

  logic en;
  logic in_acc;
  logic far_off_r;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  sfc_pkg::coord_t   cx_r, cy_r, cz_r;
  sfc_pkg::rad_q30_t rad1_r, rad2_r, rad3_r;
  sfc_pkg::aspect_t  aspect_r, aspect_nxt;

  sfc_pkg::plane_t      planes[MAX_PLANES];
  sfc_pkg::plane_t      wr_plane;
  sfc_pkg::lane_flags_t flags[NumLanes];
  logic [NumLanes-1:0]  active, below, touch;

  assign en           = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign in_acc       = in_ch.valid && en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_off_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      far_off_r <= cfg_ch.data;
    end
  end

  assign wr_plane.normal_x = in_ch.normal_x;
  assign wr_plane.normal_y = in_ch.normal_y;
  assign wr_plane.normal_z = in_ch.normal_z;
  assign wr_plane.offset   = in_ch.plane_offset;

  // a load lands before any later test reaches the product stage
  sfc_plane_store #(.MAX_PLANES(MAX_PLANES)) u_store (
    .clk      (clk),
    .wr_en    (in_acc && (in_ch.action == sfc_pkg::ACTION_LOAD)),
    .wr_idx   (in_ch.plane_index),
    .wr_plane (wr_plane),
    .planes   (planes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_ch.valid && (in_ch.action == sfc_pkg::ACTION_TEST);
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r     <= in_ch.center_x;
      cy_r     <= in_ch.center_y;
      cz_r     <= in_ch.center_z;
      rad1_r   <= {in_ch.sphere_radius, {sfc_pkg::FracAlign{1'b0}}};
      rad2_r   <= rad1_r;
      rad3_r   <= rad2_r;
      aspect_r <= aspect_nxt;
    end
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    sfc_lane u_lane (
      .clk   (clk),
      .en    (en),
      .plane (planes[i]),
      .cx    (cx_r),
      .cy    (cy_r),
      .cz    (cz_r),
      .rad   (rad3_r),
      .flags (flags[i])
    );
    assign active[i] = (i < (far_off_r ? NumInf : NumFin));
    assign below[i]  = flags[i].below;
    assign touch[i]  = flags[i].touch;
  end

  always_comb begin
    if (|(below & active)) begin
      aspect_nxt = sfc_pkg::ASPECT_OUTSIDE;
    end else if (|(touch & active)) begin
      aspect_nxt = sfc_pkg::ASPECT_INTERSECT;
    end else begin
      aspect_nxt = sfc_pkg::ASPECT_INSIDE;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.aspect = aspect_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("valid bits not cleared by reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r}) && $stable(aspect_r))
    else $error("pipeline moved during stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_vld_r) |=> out_vld_r)
    else $error("result lost at output stage");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.action == sfc_pkg::ACTION_LOAD)) |=> !s1_vld_r)
    else $error("load request entered result pipeline");

  a_aspect_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (aspect_r == sfc_pkg::ASPECT_INSIDE ||
                   aspect_r == sfc_pkg::ASPECT_OUTSIDE ||
                   aspect_r == sfc_pkg::ASPECT_INTERSECT))
    else $error("bad aspect code");

endmodule
`default_nettype wire
